>>> hw/rtl/tlbpt_pkg.sv
// Shared widths for the TLB page translator.
`default_nettype none

package tlbpt_pkg;

  // Fixed field widths of the ports.
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned FRAME_W = 8;
  localparam int unsigned CNT_W   = 32;
  // Working width for address slicing and extension.
  localparam int unsigned WIDE_W  = 32;

  typedef logic [CNT_W-1:0] cnt_t;

  // Saturating increment for the running totals.
  function automatic cnt_t sat_inc(input cnt_t v);
    cnt_t r;
    r = (v == '1) ? v : v + cnt_t'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tlb_page_translator_unit.sv
// TLB page translator: fully associative TLB with FIFO refill, page table behind it.
// An accepted word is held in the input reg (s1), then moves on to the result reg.
// Throughput: one word per cycle unless out_ready_i stalls; TLB compare, page-table
// lookup and all state updates complete in the single pass from input reg to result reg.
// Reset (rst_ni low, async): TLB empty, all pages unmapped, FIFO slot, free frame and
// both totals cleared; page-table frames are left as they are and only read once mapped.
`default_nettype none

module tlb_page_translator_unit
  import tlbpt_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 8,
  parameter int unsigned PAGE_BITS   = 8,
  parameter int unsigned TLB_ENTRIES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ADDR_W-1:0]  logical_address_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [ADDR_W-1:0]  physical_address_o,
  output logic      [FRAME_W-1:0] frame_number_o,
  output logic                    tlb_hit_o,
  output logic                    page_fault_o,
  output logic      [CNT_W-1:0]   hit_total_o,
  output logic      [CNT_W-1:0]   fault_total_o
);

  localparam int unsigned NUM_PAGES = 1 << PAGE_BITS;
  localparam int unsigned SLOT_W    = $clog2(TLB_ENTRIES);
  localparam int unsigned FREE_W    = PAGE_BITS + 1;

  typedef logic [PAGE_BITS-1:0] page_t;

  // ---------------------------------------------------------------------------
  // Handshake: input stage s1 feeds the result register; advance s1 whenever
  // the result register is empty or being drained.
  // ---------------------------------------------------------------------------
  logic              s1_valid_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic              out_valid_q;
  logic              out_free;
  logic              s1_adv;
  logic              in_acc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Page number of the incoming word (drives the page-table read address).
  logic [WIDE_W-1:0] in_addr_ext;
  page_t             in_page;

  assign in_addr_ext = WIDE_W'(logical_address_i) >> OFFSET_BITS;
  assign in_page     = in_addr_ext[PAGE_BITS-1:0];

  // Page number and offset of the word in s1.
  logic [WIDE_W-1:0]      s1_addr_ext;
  page_t                  s1_page;
  logic [OFFSET_BITS-1:0] s1_offset;

  assign s1_addr_ext = WIDE_W'(s1_addr_q) >> OFFSET_BITS;
  assign s1_page     = s1_addr_ext[PAGE_BITS-1:0];
  assign s1_offset   = s1_addr_q[OFFSET_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q <= logical_address_i;
    end
  end

  // ---------------------------------------------------------------------------
  // TLB: tags, frames and valid bits in flops, compared in parallel.
  // Lowest-numbered matching slot wins.
  // ---------------------------------------------------------------------------
  logic [TLB_ENTRIES-1:0] tlb_valid_q;
  page_t                  tlb_tag_q   [TLB_ENTRIES];
  page_t                  tlb_frame_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_match;
  logic                   tlb_hit;
  page_t                  tlb_frame;

  always_comb begin
    tlb_frame = '0;
    for (int unsigned k = 0; k < TLB_ENTRIES; k++) begin
      tlb_match[k] = tlb_valid_q[k] && (tlb_tag_q[k] == s1_page);
    end
    for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
      if (tlb_match[k]) begin
        tlb_frame = tlb_frame_q[k];
      end
    end
  end

  assign tlb_hit = |tlb_match;

  // ---------------------------------------------------------------------------
  // Page table: frames in RAM, mapped bits in flops.
  // The read is issued when a word enters s1; forward the write made in that
  // same cycle when it hits the same page.
  // ---------------------------------------------------------------------------
  logic [NUM_PAGES-1:0] map_valid_q;
  logic [FREE_W-1:0]    free_frame_q;
  page_t                ram_rdata;
  logic                 fwd_q;
  page_t                fwd_data_q;
  page_t                tbl_frame;
  logic                 miss;
  logic                 fault;
  page_t                new_frame;
  logic                 map_we;

  assign miss      = !tlb_hit;
  assign fault     = miss && !map_valid_q[s1_page];
  assign new_frame = free_frame_q[PAGE_BITS-1:0];
  assign map_we    = s1_adv && fault;
  assign tbl_frame = fwd_q ? fwd_data_q : ram_rdata;

  tlbpt_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (NUM_PAGES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (s1_page),
    .wdata_i (new_frame),
    .re_i    (in_acc),
    .raddr_i (in_page),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= map_we && (s1_page == in_page);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= new_frame;
    end
  end

  // Frame for this word: TLB, freshly given frame, or the page table.
  page_t frame;

  always_comb begin
    if (tlb_hit) begin
      frame = tlb_frame;
    end else if (fault) begin
      frame = new_frame;
    end else begin
      frame = tbl_frame;
    end
  end

  // ---------------------------------------------------------------------------
  // State update on advance.
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0] fifo_slot_q;
  logic [SLOT_W-1:0] fifo_slot_d;
  logic [FREE_W-1:0] free_frame_d;
  cnt_t              hit_cnt_q;
  cnt_t              hit_cnt_d;
  cnt_t              fault_cnt_q;
  cnt_t              fault_cnt_d;

  assign fifo_slot_d  = (fifo_slot_q == SLOT_W'(TLB_ENTRIES - 1)) ?
                        '0 : fifo_slot_q + SLOT_W'(1);
  // Stop once every page has been given a frame (top bit set).
  assign free_frame_d = free_frame_q[PAGE_BITS] ? free_frame_q :
                        free_frame_q + FREE_W'(1);
  assign hit_cnt_d    = tlb_hit ? sat_inc(hit_cnt_q) : hit_cnt_q;
  assign fault_cnt_d  = fault ? sat_inc(fault_cnt_q) : fault_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q  <= '0;
      map_valid_q  <= '0;
      fifo_slot_q  <= '0;
      free_frame_q <= '0;
      hit_cnt_q    <= '0;
      fault_cnt_q  <= '0;
      for (int unsigned k = 0; k < TLB_ENTRIES; k++) begin
        tlb_tag_q[k]   <= '0;
        tlb_frame_q[k] <= '0;
      end
    end else if (s1_adv) begin
      hit_cnt_q   <= hit_cnt_d;
      fault_cnt_q <= fault_cnt_d;
      if (fault) begin
        map_valid_q[s1_page] <= 1'b1;
        free_frame_q         <= free_frame_d;
      end
      // Refill the FIFO slot on every miss.
      if (miss) begin
        tlb_valid_q[fifo_slot_q] <= 1'b1;
        tlb_tag_q[fifo_slot_q]   <= s1_page;
        tlb_frame_q[fifo_slot_q] <= frame;
        fifo_slot_q              <= fifo_slot_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic [WIDE_W-1:0] phys_ext;
  logic [WIDE_W-1:0] frame_ext;
  logic [ADDR_W-1:0]  phys_q;
  logic [FRAME_W-1:0] frame_q;
  logic               hit_q;
  logic               fault_q;
  cnt_t               hit_total_q;
  cnt_t               fault_total_q;

  assign phys_ext  = WIDE_W'({frame, s1_offset});
  assign frame_ext = WIDE_W'(frame);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      phys_q        <= phys_ext[ADDR_W-1:0];
      frame_q       <= frame_ext[FRAME_W-1:0];
      hit_q         <= tlb_hit;
      fault_q       <= fault;
      hit_total_q   <= hit_cnt_d;
      fault_total_q <= fault_cnt_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = phys_q;
  assign frame_number_o     = frame_q;
  assign tlb_hit_o          = hit_q;
  assign page_fault_o       = fault_q;
  assign hit_total_o        = hit_total_q;
  assign fault_total_o      = fault_total_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // A fault maps the page, so the same page cannot fault again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_we |=> map_valid_q[$past(s1_page)])
    else $error("faulted page not marked mapped");

  // Free-frame pointer never runs past the page count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_frame_q <= FREE_W'(NUM_PAGES))
    else $error("free frame pointer out of range");

  // A hit and a fault never come together in one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> !(hit_q && fault_q))
    else $error("hit and fault in same result");

  // Each unsaturated hit moves the hit count up by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && tlb_hit && (hit_cnt_q != '1)) |=> (hit_cnt_q == $past(hit_cnt_q) + cnt_t'(1)))
    else $error("hit count did not advance");

endmodule

`default_nettype wire

>>> hw/rtl/tlbpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tlbpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read returns the old contents on a same-address write.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> tb/tlb_translation_checker.sv
`timescale 1ns / 100ps
// Translation checker: tracks TLB and page-table state and compares every result word.
module tlb_translation_checker
  import tlbpt_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 8,
  parameter int unsigned PAGE_BITS   = 8,
  parameter int unsigned TLB_ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [ADDR_W-1:0]  logical_address_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [ADDR_W-1:0]  physical_address_i,
  input  logic [FRAME_W-1:0] frame_number_i,
  input  logic               tlb_hit_i,
  input  logic               page_fault_i,
  input  logic [CNT_W-1:0]   hit_total_i,
  input  logic [CNT_W-1:0]   fault_total_i,
  output int                 mismatches_o,
  output int                 pending_o
);

  localparam int unsigned NUM_PAGES = 1 << PAGE_BITS;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  phys_addr;
    logic [FRAME_W-1:0] frame;
    logic               hit;
    logic               fault;
    cnt_t               hits;
    cnt_t               faults;
  } translation_t;

  page_t        slot_page  [TLB_ENTRIES];
  logic         slot_live  [TLB_ENTRIES];
  page_t        slot_frame [TLB_ENTRIES];
  page_t        page_frame [NUM_PAGES];
  logic         page_mapped[NUM_PAGES];
  int unsigned  refill_slot;
  int unsigned  next_frame;
  cnt_t         hit_count;
  cnt_t         fault_count;
  translation_t translation_q[$];
  translation_t want;

  // Walk the TLB, fall back to the page table, refill the FIFO slot on a miss.
  function automatic translation_t translate(input logic [ADDR_W-1:0] laddr);
    logic [WIDE_W-1:0] wide;
    page_t             page;
    page_t             frame;
    logic              found;
    logic              fault;
    translation_t      t;
    int                k;
    wide  = WIDE_W'(laddr);
    page  = page_t'(wide >> OFFSET_BITS);
    frame = '0;
    found = 1'b0;
    fault = 1'b0;
    for (k = 0; k < TLB_ENTRIES; k++) begin
      if (!found && slot_live[k] && slot_page[k] == page) begin
        found = 1'b1;
        frame = slot_frame[k];
      end
    end
    if (found) begin
      hit_count = (hit_count == '1) ? hit_count : hit_count + 1'b1;
    end else begin
      if (!page_mapped[page]) begin
        fault             = 1'b1;
        fault_count       = (fault_count == '1) ? fault_count : fault_count + 1'b1;
        page_frame[page]  = page_t'(next_frame);
        page_mapped[page] = 1'b1;
        if (next_frame < NUM_PAGES) next_frame++;
      end
      frame = page_frame[page];
      if (refill_slot >= TLB_ENTRIES) refill_slot = 0;
      slot_page[refill_slot]  = page;
      slot_frame[refill_slot] = frame;
      slot_live[refill_slot]  = 1'b1;
      refill_slot = (refill_slot + 1) % TLB_ENTRIES;
    end
    t.phys_addr = ADDR_W'((WIDE_W'(frame) << OFFSET_BITS) |
                          (wide & WIDE_W'((64'd1 << OFFSET_BITS) - 1)));
    t.frame     = FRAME_W'(frame);
    t.hit       = found;
    t.fault     = fault;
    t.hits      = hit_count;
    t.faults    = fault_count;
    return t;
  endfunction

  task automatic compare_field(input string name, input logic [CNT_W-1:0] exp_v,
                               input logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        slot_page[i]  = '0;
        slot_live[i]  = 1'b0;
        slot_frame[i] = '0;
      end
      for (int i = 0; i < NUM_PAGES; i++) begin
        page_mapped[i] = 1'b0;
      end
      refill_slot = 0;
      next_frame  = 0;
      hit_count   = '0;
      fault_count = '0;
      translation_q.delete();
    end else begin
      // Retire the result word first: it always belongs to an earlier address word.
      if (out_valid_i && out_ready_i) begin
        if (translation_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual phys %0h", $time,
                   physical_address_i);
          mismatches_o++;
        end else begin
          want = translation_q.pop_front();
          compare_field("physical_address", want.phys_addr, physical_address_i);
          compare_field("frame_number", want.frame, frame_number_i);
          compare_field("tlb_hit", want.hit, tlb_hit_i);
          compare_field("page_fault", want.fault, page_fault_i);
          compare_field("hit_total", want.hits, hit_total_i);
          compare_field("fault_total", want.faults, fault_total_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        translation_q.push_back(translate(logical_address_i));
      end
    end
    pending_o = translation_q.size();
  end

endmodule

>>> tb/tb_tlb_page_translator_unit.sv
`timescale 1ns / 100ps
// Testbench top: drives address words into the page translator and reports the verdict.
module tb_tlb_page_translator_unit
  import tlbpt_pkg::*;
;

  localparam int unsigned OFFSET_BITS  = 8;
  localparam int unsigned PAGE_BITS    = 8;
  localparam int unsigned TLB_ENTRIES  = 16;
  localparam int unsigned RANDOM_WORDS = 2000;
  localparam int unsigned HOT_PAGES    = 8;
  // Worst case is roughly the word count times the longest gap, stall and pipeline latency; allow 10x.
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  // Settle time after the pipeline has drained, before the final verdict.
  localparam int unsigned SETTLE_CYCLES = 8;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  logic [ADDR_W-1:0]  logical_address;
  logic               out_valid;
  logic               out_ready;
  logic [ADDR_W-1:0]  physical_address;
  logic [FRAME_W-1:0] frame_number;
  logic               tlb_hit;
  logic               page_fault;
  logic [CNT_W-1:0]   hit_total;
  logic [CNT_W-1:0]   fault_total;
  int                 mismatches;
  int                 pending;

  int unsigned        cycle_count;
  int unsigned        sent;
  bit                 steady_feed;
  logic [7:0]         hot_page[HOT_PAGES];
  logic [7:0]         sweep_page;

  tlb_page_translator_unit #(
    .OFFSET_BITS (OFFSET_BITS),
    .PAGE_BITS   (PAGE_BITS),
    .TLB_ENTRIES (TLB_ENTRIES)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .logical_address_i  (logical_address),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .physical_address_o (physical_address),
    .frame_number_o     (frame_number),
    .tlb_hit_o          (tlb_hit),
    .page_fault_o       (page_fault),
    .hit_total_o        (hit_total),
    .fault_total_o      (fault_total)
  );

  // The checker sees both channels exactly as the block does and owns all prediction.
  tlb_translation_checker #(
    .OFFSET_BITS (OFFSET_BITS),
    .PAGE_BITS   (PAGE_BITS),
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .logical_address_i  (logical_address),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .physical_address_i (physical_address),
    .frame_number_i     (frame_number),
    .tlb_hit_i          (tlb_hit),
    .page_fault_i       (page_fault),
    .hit_total_i        (hit_total),
    .fault_total_i      (fault_total),
    .mismatches_o       (mismatches),
    .pending_o          (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hold reset low at the start, then release it for good.
  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: a hung handshake or a lost result word ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_tlb_page_translator_unit: FAIL");
      $finish;
    end
  end

  // Present one address word and hold it until the block takes it. The gap before
  // it is drawn per word; every 64 words a coin decides whether to run back to back.
  task automatic send_word(input logic [ADDR_W-1:0] addr);
    int gap;
    if (sent % 64 == 0) steady_feed = ($urandom_range(0, 3) == 0);
    gap = steady_feed ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid        <= 1'b1;
    logical_address <= addr;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    sent++;
  endtask

  // Drop valid and wait until every predicted result word has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mix of access patterns: half the time a small hot set so the TLB hits, some uniform
  // pages to force misses and evictions, and a sweep that maps every page in turn.
  function automatic logic [ADDR_W-1:0] next_address();
    int         pick;
    logic [7:0] page;
    if ($urandom_range(0, 19) == 0) begin
      hot_page[$urandom_range(0, HOT_PAGES - 1)] = 8'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      page = hot_page[$urandom_range(0, HOT_PAGES - 1)];
    end else if (pick < 8) begin
      page = 8'($urandom_range(0, 255));
    end else begin
      page       = sweep_page;
      sweep_page = sweep_page + 1'b1;
    end
    return {page, 8'($urandom_range(0, 255))};
  endfunction

  initial begin : address_source
    in_valid        = 1'b0;
    logical_address = '0;
    sweep_page      = '0;
    for (int i = 0; i < HOT_PAGES; i++) hot_page[i] = 8'($urandom_range(0, 255));
    wait (rst_ni);
    @(posedge clk_i);

    // Lowest and highest pages: first touch faults, second touch hits the TLB.
    send_word(16'h0000);
    send_word(16'h00FF);
    send_word(16'hFFFF);
    send_word(16'hFF00);
    // Sixteen fresh pages wrap the FIFO pointer and evict both pages above.
    for (int p = 1; p <= 16; p++) begin
      send_word(ADDR_W'((p << OFFSET_BITS) | $urandom_range(0, 255)));
    end
    // Evicted but still mapped: TLB miss without a page fault, old frame reused.
    send_word(16'h0012);
    send_word(16'hFFAA);

    // Let the pipeline empty completely before the random part.
    wait_for_results();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) wait_for_results();
      send_word(next_address());
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_tlb_page_translator_unit: PASS");
    end else begin
      $display("tb_tlb_page_translator_unit: FAIL");
    end
    $finish;
  end

  // Result side: stall a random number of cycles per word, with stretches of
  // always-ready so back-to-back results also get exercised.
  initial begin : result_sink
    int stall;
    int taken;
    bit steady_drain;
    out_ready = 1'b0;
    taken     = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 50 == 0) steady_drain = ($urandom_range(0, 3) == 0);
      stall = steady_drain ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
      taken++;
    end
  end

endmodule
